FILE: rtl/endpoint_set_table_core_assert.svh
// ----------------------------------------------------------------------------
// endpoint set table assertion macros
// concurrent property wrappers clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ENDPOINT_SET_TABLE_CORE_ASSERT_SVH
`define ENDPOINT_SET_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define ESTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("endpoint set table assertion failed");

// next-cycle implication
`define ESTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("endpoint set table assertion failed");

`endif

FILE: rtl/ests_pkg.sv
// ----------------------------------------------------------------------------
// endpoint set table package
// shared types and codes for the request, response and table entry
// ----------------------------------------------------------------------------
package ests_pkg;

  typedef logic [1:0] func_t;
  typedef logic [1:0] status_t;
  typedef logic [3:0] slot_t;
  typedef logic [4:0] count_t;

  localparam func_t FUNC_SEARCH = 2'd0;
  localparam func_t FUNC_INSERT = 2'd1;
  localparam func_t FUNC_DELETE = 2'd2;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_ABSENT  = 2'd1;
  localparam status_t ST_PRESENT = 2'd2;
  localparam status_t ST_FULL    = 2'd3;

  typedef struct packed {
    logic        valid;
    logic [31:0] address;
    logic [15:0] port;
  } entry_t;

  typedef struct packed {
    logic clr;
    logic en;
  } scan_ctl_t;

  typedef struct packed {
    logic hit;
    logic free;
  } scan_flags_t;

endpackage

FILE: rtl/ests_if.sv
// ----------------------------------------------------------------------------
// endpoint set table channels
// valid/ready request and response interfaces
// ----------------------------------------------------------------------------
interface ests_req_if;
  logic                valid;
  logic                ready;
  ests_pkg::func_t     func;
  logic [31:0]         peer_addr;
  logic [15:0]         port;

  modport source (output valid, output func, output peer_addr, output port, input ready);
  modport sink   (input valid, input func, input peer_addr, input port, output ready);
endinterface

interface ests_rsp_if;
  logic                valid;
  logic                ready;
  ests_pkg::status_t   status;
  ests_pkg::slot_t     slot;
  ests_pkg::count_t    entry_count;

  modport source (output valid, output status, output slot, output entry_count, input ready);
  modport sink   (input valid, input status, input slot, input entry_count, output ready);
endinterface

FILE: rtl/ests_mem.sv
// ----------------------------------------------------------------------------
// endpoint set table storage
// single write port, single registered read port
// ----------------------------------------------------------------------------
module ests_mem #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  ests_pkg::entry_t    wdata,
  input  logic [IDX_W-1:0]    raddr,
  output ests_pkg::entry_t    rdata
);
  import ests_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/ests_scan.sv
// ----------------------------------------------------------------------------
// endpoint set table scan unit
// compares one entry a cycle while enabled and keeps the lowest hit and lowest free slot
// ----------------------------------------------------------------------------
module ests_scan #(
  parameter int IDX_W = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ests_pkg::scan_ctl_t   ctl,
  input  logic [IDX_W-1:0]      idx,
  input  ests_pkg::entry_t      rd_entry,
  input  logic [31:0]           key_address,
  input  logic [15:0]           key_port,
  output ests_pkg::scan_flags_t flags,
  output logic [IDX_W-1:0]      hit_idx,
  output logic [IDX_W-1:0]      free_idx
);
  import ests_pkg::*;

  scan_flags_t      flags_r, flags_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic             match;
  logic             empty;

  assign match = rd_entry.valid && (rd_entry.address == key_address) &&
                 (rd_entry.port == key_port);
  assign empty = !rd_entry.valid;

  always_comb begin
    flags_nxt    = flags_r;
    hit_idx_nxt  = hit_idx_r;
    free_idx_nxt = free_idx_r;
    if (ctl.clr) begin
      flags_nxt = '0;
    end else if (ctl.en) begin
      if (match && !flags_r.hit) begin
        flags_nxt.hit = 1'b1;
        hit_idx_nxt   = idx;
      end
      if (empty && !flags_r.free) begin
        flags_nxt.free = 1'b1;
        free_idx_nxt   = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
  end

  assign flags    = flags_r;
  assign hit_idx  = hit_idx_r;
  assign free_idx = free_idx_r;

endmodule

FILE: rtl/endpoint_set_table_core.sv
// ----------------------------------------------------------------------------
// endpoint set table core
// bounded set of address/port endpoints with search, insert and delete
// ----------------------------------------------------------------------------
// channel   dir  fields                          handshake
// in_req    in   func, peer_addr, port           valid/ready
// out_rsp   out  status, slot, entry_count       valid/ready
//
// a request passes through these steps in order: one to accept, one table read per
// entry through the single read port, one to drain the compare and one to
// decide and write back.
// after reset a clearing pass marks every entry invalid; no request is taken
// meanwhile. a new request is taken while a response waits; the decide step
// holds until the response register is free.
// ----------------------------------------------------------------------------
module endpoint_set_table_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  ests_req_if.sink      in_req,
  ests_rsp_if.source    out_rsp
);
  import ests_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_TAIL  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             cmp_en_r;
  logic [IDX_W-1:0] cmp_idx_r;
  func_t            func_r;
  logic [31:0]      key_addr_r;
  logic [15:0]      key_port_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  status_t          out_status_r;
  slot_t            out_slot_r;
  count_t           out_count_r;

  logic             in_fire;
  logic             done_fire;
  status_t          status_sel;
  logic [IDX_W-1:0] slot_sel;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  entry_t           mem_rdata;

  scan_ctl_t        scan_ctl;
  scan_flags_t      scan_flags;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] free_idx;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign done_fire    = (state_r == S_DONE) && (!out_valid_r || out_rsp.ready);

  assign scan_ctl.clr = in_fire;
  assign scan_ctl.en  = cmp_en_r;

  ests_mem #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx_r),
    .rdata (mem_rdata)
  );

  ests_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (scan_ctl),
    .idx         (cmp_idx_r),
    .rd_entry    (mem_rdata),
    .key_address (key_addr_r),
    .key_port    (key_port_r),
    .flags       (scan_flags),
    .hit_idx     (hit_idx),
    .free_idx    (free_idx)
  );

  // decision and write back
  always_comb begin
    status_sel        = ST_ABSENT;
    slot_sel          = '0;
    count_nxt         = count_r;
    mem_we            = 1'b0;
    mem_waddr         = idx_r;
    mem_wdata.valid   = 1'b0;
    mem_wdata.address = key_addr_r;
    mem_wdata.port    = key_port_r;
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
    end else begin
      case (func_r)
        FUNC_INSERT: begin
          if (scan_flags.hit) begin
            status_sel = ST_PRESENT;
            slot_sel   = hit_idx;
          end else if (scan_flags.free) begin
            status_sel      = ST_OK;
            slot_sel        = free_idx;
            count_nxt       = count_r + CNT_W'(1);
            mem_we          = done_fire;
            mem_waddr       = free_idx;
            mem_wdata.valid = 1'b1;
          end else begin
            status_sel = ST_FULL;
          end
        end
        FUNC_DELETE: begin
          if (scan_flags.hit) begin
            status_sel = ST_OK;
            slot_sel   = hit_idx;
            count_nxt  = count_r - CNT_W'(1);
            mem_we     = done_fire;
            mem_waddr  = hit_idx;
          end
        end
        default: begin
          if (scan_flags.hit) begin
            status_sel = ST_OK;
            slot_sel   = hit_idx;
          end
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_CLEAR: begin
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        idx_nxt = '0;
        if (in_fire) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (done_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      cmp_en_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      cmp_en_r <= (state_r == S_SCAN);
      if (done_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= idx_r;
    if (in_fire) begin
      func_r     <= in_req.func;
      key_addr_r <= in_req.peer_addr;
      key_port_r <= in_req.port;
    end
    if (done_fire) begin
      out_status_r <= status_sel;
      out_slot_r   <= slot_t'(slot_sel);
      out_count_r  <= count_t'(count_nxt);
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.slot        = out_slot_r;
  assign out_rsp.entry_count = out_count_r;

endmodule

FILE: rtl/ests_chk.sv
// ----------------------------------------------------------------------------
// endpoint set table checker
// port-level properties of the core, attached by bind
// ----------------------------------------------------------------------------
`include "endpoint_set_table_core_assert.svh"

module ests_chk #(
  parameter int TABLE_DEPTH = 16
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ests_pkg::status_t out_status,
  input ests_pkg::slot_t   out_slot,
  input ests_pkg::count_t  out_entry_count
);
  import ests_pkg::*;

  // one request in flight: no request taken right after one
  `ESTS_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // a response waits until taken
  `ESTS_ASSERT_NEXT(a_rsp_holds, out_valid && !out_ready, out_valid)

  // no slot reported when nothing matched or nothing was written
  `ESTS_ASSERT_NOW(a_no_slot, out_valid && (out_status == ST_ABSENT || out_status == ST_FULL),
                   out_slot == '0)

  // a full answer only with every slot in use
  `ESTS_ASSERT_NOW(a_full_count, out_valid && (out_status == ST_FULL),
                   out_entry_count == count_t'(TABLE_DEPTH))

endmodule

bind endpoint_set_table_core ests_chk #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_ests_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_req.valid),
  .in_ready        (in_req.ready),
  .out_valid       (out_rsp.valid),
  .out_ready       (out_rsp.ready),
  .out_status      (out_rsp.status),
  .out_slot        (out_rsp.slot),
  .out_entry_count (out_rsp.entry_count)
);

FILE: dv/tb_endpoint_set_table_core.sv
// ----------------------------------------------------------------------------
// endpoint set table core testbench
// drives search, insert, delete and spare-selector requests through the request channel with
// random gaps and response back-pressure, keeps its own copy of the table to
// work out each answer, and checks every response field in order
// ----------------------------------------------------------------------------
module tb_endpoint_set_table_core;
  import ests_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_OFF    = 400;
  localparam int HOLD_EVERY  = 700;
  localparam int PRINT_CAP   = 100;
  localparam func_t FUNC_SPARE = 2'd3;

  typedef struct packed {
    func_t       func;
    logic [31:0] addr;
    logic [15:0] port;
  } peer_req_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
  } endpoint_t;

  typedef struct packed {
    status_t status;
    slot_t   slot;
    count_t  entry_count;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n;

  ests_req_if req_ch ();
  ests_rsp_if rsp_ch ();

  endpoint_set_table_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow table
  bit          tbl_used [TABLE_DEPTH];
  logic [31:0] tbl_addr [TABLE_DEPTH];
  logic [15:0] tbl_port [TABLE_DEPTH];
  int          tbl_total;

  peer_req_t request_q [$];
  answer_t   answer_q  [$];
  endpoint_t peer_pool [$];

  int errors      = 0;
  int req_taken   = 0;
  int rsp_seen    = 0;
  int total_items = 0;
  int send_gap    = 0;
  int send_calm   = 0;
  int ready_stall = 0;
  int ready_calm  = 0;
  int next_hold_at = 150;
  int idle_cycles = 0;

  function automatic answer_t apply_request(func_t f, logic [31:0] a, logic [15:0] p);
    answer_t ans;
    int hit;
    int free_idx;
    int i;
    hit = -1;
    free_idx = -1;
    for (i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (tbl_used[i] && tbl_addr[i] == a && tbl_port[i] == p) hit = i;
      if (!tbl_used[i]) free_idx = i;
    end
    ans.status = ST_OK;
    ans.slot = '0;
    case (f)
      FUNC_INSERT: begin
        if (hit >= 0) begin
          ans.status = ST_PRESENT;
          ans.slot = slot_t'(hit);
        end else if (free_idx < 0) begin
          ans.status = ST_FULL;
        end else begin
          tbl_used[free_idx] = 1'b1;
          tbl_addr[free_idx] = a;
          tbl_port[free_idx] = p;
          tbl_total++;
          ans.slot = slot_t'(free_idx);
        end
      end
      FUNC_DELETE: begin
        if (hit >= 0) begin
          tbl_used[hit] = 1'b0;
          tbl_total--;
          ans.slot = slot_t'(hit);
        end else begin
          ans.status = ST_ABSENT;
        end
      end
      default: begin
        if (hit >= 0) ans.slot = slot_t'(hit);
        else ans.status = ST_ABSENT;
      end
    endcase
    ans.entry_count = count_t'(tbl_total);
    return ans;
  endfunction

  // mostly short gaps, a few long, with stretches of none
  function automatic int draw_gap(inout int calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(12, 60);
  endfunction

  function automatic func_t draw_func(int ins_w, int del_w, int srch_w);
    int r;
    r = $urandom_range(0, 99);
    if (r < ins_w) return FUNC_INSERT;
    if (r < ins_w + del_w) return FUNC_DELETE;
    if (r < ins_w + del_w + srch_w) return FUNC_SEARCH;
    return FUNC_SPARE;
  endfunction

  function automatic void queue_request(func_t f, logic [31:0] a, logic [15:0] p);
    peer_req_t item;
    item.func = f;
    item.addr = a;
    item.port = p;
    request_q.push_back(item);
  endfunction

  task automatic report_mismatch(string what);
    if (errors < PRINT_CAP) $display("mismatch: %0s", what);
    errors++;
  endtask

  // request driver
  always @(posedge clk) begin : req_drive
    peer_req_t nxt;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        answer_q.push_back(apply_request(req_ch.func, req_ch.peer_addr, req_ch.port));
        req_taken++;
        send_gap = draw_gap(send_calm);
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap > 0 || request_q.size() == 0) begin
          if (send_gap > 0) send_gap--;
          req_ch.valid <= 1'b0;
        end else begin
          nxt = request_q.pop_front();
          req_ch.valid     <= 1'b1;
          req_ch.func      <= nxt.func;
          req_ch.peer_addr <= nxt.addr;
          req_ch.port      <= nxt.port;
        end
      end
    end
  end

  // response ready with random stalls and long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      ready_stall = 0;
    end else begin
      if (rsp_seen == next_hold_at) begin
        ready_stall = HOLD_OFF;
        next_hold_at = next_hold_at + HOLD_EVERY;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
        ready_stall = draw_gap(ready_calm);
      end else if (ready_stall == 0 && ready_calm == 0 && $urandom_range(0, 99) < 4) begin
        ready_stall = $urandom_range(1, 8);
      end
      if (ready_stall > 0) begin
        ready_stall--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // response monitor
  always @(posedge clk) begin : rsp_check
    answer_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      rsp_seen <= rsp_seen + 1;
      if (answer_q.size() == 0) begin
        report_mismatch($sformatf("response with no request outstanding, status %0d",
                                  rsp_ch.status));
      end else begin
        want = answer_q.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch($sformatf("response %0d status got %0d expected %0d",
                                    rsp_seen, rsp_ch.status, want.status));
        if (rsp_ch.slot !== want.slot)
          report_mismatch($sformatf("response %0d slot got %0d expected %0d",
                                    rsp_seen, rsp_ch.slot, want.slot));
        if (rsp_ch.entry_count !== want.entry_count)
          report_mismatch($sformatf("response %0d entry_count got %0d expected %0d",
                                    rsp_seen, rsp_ch.entry_count, want.entry_count));
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int i;
    int blk;
    int r;
    int ins_w;
    int del_w;
    func_t f;
    endpoint_t ep;

    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.func = FUNC_SEARCH;
    req_ch.peer_addr = '0;
    req_ch.port = '0;
    rsp_ch.ready = 1'b0;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      tbl_used[i] = 1'b0;
      tbl_addr[i] = '0;
      tbl_port[i] = '0;
    end
    tbl_total = 0;

    // empty table, extremes, partial matches, spare selector, lowest free slot
    queue_request(FUNC_SEARCH, 32'h0000_0000, 16'h0000);
    queue_request(FUNC_DELETE, 32'h0000_0000, 16'h0000);
    queue_request(FUNC_INSERT, 32'h0000_0000, 16'h0000);
    queue_request(FUNC_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
    queue_request(FUNC_INSERT, 32'h0000_0000, 16'h0000);
    queue_request(FUNC_SEARCH, 32'hFFFF_FFFF, 16'h0000);
    queue_request(FUNC_SEARCH, 32'h0000_0000, 16'hFFFF);
    queue_request(FUNC_SPARE,  32'hFFFF_FFFF, 16'hFFFF);
    queue_request(FUNC_DELETE, 32'h0000_0000, 16'h0000);
    queue_request(FUNC_INSERT, 32'h1234_5678, 16'hABCD);
    peer_pool.push_back({32'h0000_0000, 16'h0000});
    peer_pool.push_back({32'hFFFF_FFFF, 16'hFFFF});
    peer_pool.push_back({32'h1234_5678, 16'hABCD});
    // fill up, then a new endpoint and a duplicate while full
    for (i = 0; i < TABLE_DEPTH - 2; i++) begin
      ep.addr = 32'hC0A8_0100 + i * 32'h0101_0011;
      ep.port = 16'h1F90 + i[15:0];
      queue_request(FUNC_INSERT, ep.addr, ep.port);
      peer_pool.push_back(ep);
    end
    queue_request(FUNC_INSERT, 32'h8000_0001, 16'h8001);
    queue_request(FUNC_INSERT, 32'hFFFF_FFFF, 16'hFFFF);

    for (i = 0; i < 12; i++) begin
      ep.addr = $urandom();
      ep.port = 16'($urandom_range(0, 65535));
      peer_pool.push_back(ep);
    end

    // random phases: fill-heavy, balanced, drain-heavy
    for (blk = 0; blk < 15; blk++) begin
      case (blk % 3)
        0: begin ins_w = 60; del_w = 15; end
        1: begin ins_w = 35; del_w = 35; end
        default: begin ins_w = 15; del_w = 60; end
      endcase
      for (i = 0; i < 100; i++) begin
        f = draw_func(ins_w, del_w, 95 - ins_w - del_w);
        r = $urandom_range(0, 99);
        ep = peer_pool[$urandom_range(0, peer_pool.size() - 1)];
        if (r >= 88) begin
          ep.addr = $urandom();
          ep.port = 16'($urandom_range(0, 65535));
        end else if (r >= 75) begin
          if (r[0]) ep.addr = ep.addr ^ (32'h1 << $urandom_range(0, 31));
          else ep.port = ep.port ^ (16'h1 << $urandom_range(0, 15));
        end
        queue_request(f, ep.addr, ep.port);
      end
    end
    total_items = request_q.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (req_taken < total_items || answer_q.size() != 0);
    repeat (2 * TABLE_DEPTH + 8) @(posedge clk);

    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/ests_pkg.sv
rtl/ests_if.sv
rtl/ests_mem.sv
rtl/ests_scan.sv
rtl/endpoint_set_table_core.sv
rtl/ests_chk.sv
dv/tb_endpoint_set_table_core.sv
